/* src/mscs_pkg.sv */
package mscs_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] CodePack    = 8'hBA;
  localparam logic [7:0] CodeSystem  = 8'hBB;
  localparam logic [7:0] CodeSeqHdr  = 8'hB3;
  localparam logic [7:0] CodeGop     = 8'hB8;
  localparam logic [7:0] CodePicture = 8'h00;
  localparam logic [7:0] CodeOne     = 8'h01;
  localparam logic [7:0] SliceLast   = 8'hAF;
  localparam logic [7:0] AudioFirst  = 8'hC0;
  localparam logic [7:0] AudioLast   = 8'hDF;
  localparam logic [7:0] VideoFirst  = 8'hE0;

  localparam logic [3:0] KindPack    = 4'd0;
  localparam logic [3:0] KindSystem  = 4'd1;
  localparam logic [3:0] KindSeqHdr  = 4'd2;
  localparam logic [3:0] KindGop     = 4'd3;
  localparam logic [3:0] KindPicture = 4'd4;
  localparam logic [3:0] KindSlice   = 4'd5;
  localparam logic [3:0] KindVideo   = 4'd6;
  localparam logic [3:0] KindAudio   = 4'd7;
  localparam logic [3:0] KindOther   = 4'd8;

  localparam logic [1:0] PicI     = 2'd0;
  localparam logic [1:0] PicP     = 2'd1;
  localparam logic [1:0] PicOther = 2'd2;

  // operations handed from the scanner to the result builder
  typedef enum logic [1:0] {
    OP_EVENT    = 2'd0,
    OP_SEQ_BYTE = 2'd1,
    OP_SEQ_LAST = 2'd2,
    OP_PIC_TYPE = 2'd3
  } mscs_op_e;

  typedef struct packed {
    mscs_op_e   op;
    logic [7:0] data;
  } mscs_req_t;

  function automatic logic [3:0] classify_code(input logic [7:0] c);
    logic [3:0] k;
    if (c == CodePack) k = KindPack;
    else if (c == CodeSystem) k = KindSystem;
    else if (c == CodeSeqHdr) k = KindSeqHdr;
    else if (c == CodeGop) k = KindGop;
    else if (c == CodePicture) k = KindPicture;
    else if (c <= SliceLast) k = KindSlice;
    else if (c >= AudioFirst && c <= AudioLast) k = KindAudio;
    else if (c >= VideoFirst) k = KindVideo;
    else k = KindOther;
    return k;
  endfunction

  function automatic logic [15:0] rate_lookup(input logic [3:0] rc);
    logic [15:0] r;
    unique case (rc)
      4'd1:    r = 16'd23976;
      4'd2:    r = 16'd24000;
      4'd3:    r = 16'd25000;
      4'd4:    r = 16'd29970;
      4'd5:    r = 16'd30000;
      4'd6:    r = 16'd50000;
      4'd7:    r = 16'd59940;
      default: r = 16'd60000;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] picture_lookup(input logic [7:0] b);
    logic [2:0] t;
    logic [1:0] p;
    t = b[5:3];
    if (t == 3'd1) p = PicI;
    else if (t == 3'd2) p = PicP;
    else p = PicOther;
    return p;
  endfunction

endpackage

/* src/mpeg_start_code_scanner_core.sv */
// MPEG start code scanner.
// Input channel: one stream byte per request on stream_byte_i (in_valid_i /
// in_ready_o). The scanner finds 00 00 01 prefixes (longer zero runs allowed)
// and classifies the code byte that follows.
// Output channel: one request per completed start code (out_valid_o /
// out_ready_i) with kind, code byte, and for a sequence header the frame
// size and rate, for a picture the coding type; unused fields are zero.
// Throughput: one byte per cycle while the queue has room. The front
// scanner and the result builder are separated by a small request queue
// (QueueDepth entries), which each result passes before the output register.
// When the receiver stalls, the output register holds its result and the
// queue fills; in_ready_o drops only once the queue is full.
// Reset: asynchronous, active low; scanning restarts searching for a
// prefix, the queue and the output register are emptied.
module mpeg_start_code_scanner_core import mscs_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  event_kind_o,
  output logic [7:0]  code_value_o,
  output logic [11:0] frame_width_o,
  output logic [11:0] frame_height_o,
  output logic [3:0]  rate_code_o,
  output logic [15:0] rate_milli_fps_o,
  output logic [1:0]  picture_class_o
);

  logic      push_valid, push_ready;
  mscs_req_t push_req;
  logic      pop_valid, pop;
  mscs_req_t pop_req;

  mscs_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .stream_byte_i,
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_req_o   (push_req)
  );

  mscs_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_req_i   (push_req),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_req_o    (pop_req)
  );

  mscs_back u_back (
    .clk_i,
    .rst_ni,
    .req_valid_i (pop_valid),
    .req_i       (pop_req),
    .pop_o       (pop),
    .out_valid_o,
    .out_ready_i,
    .event_kind_o,
    .code_value_o,
    .frame_width_o,
    .frame_height_o,
    .rate_code_o,
    .rate_milli_fps_o,
    .picture_class_o
  );

endmodule

/* src/mscs_front.sv */
module mscs_front import mscs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [7:0] stream_byte_i,
  input  logic      push_ready_i,
  output logic      push_valid_o,
  output mscs_req_t push_req_o
);

  typedef enum logic [2:0] {
    ST_SEARCH = 3'd0,
    ST_CODE   = 3'd1,
    ST_SEQ    = 3'd2,
    ST_PSKIP  = 3'd3,
    ST_PREAD  = 3'd4
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [1:0] zero_run_q, zero_run_d;
  logic [1:0] hdr_cnt_q, hdr_cnt_d;
  logic       accept;
  logic       push;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  always_comb begin
    phase_d         = phase_q;
    zero_run_d      = zero_run_q;
    hdr_cnt_d       = hdr_cnt_q;
    push            = 1'b0;
    push_req_o.op   = OP_EVENT;
    push_req_o.data = stream_byte_i;
    unique case (phase_q)
      ST_CODE: begin
        zero_run_d = 2'd0;
        if (stream_byte_i == CodeSeqHdr) begin
          hdr_cnt_d = 2'd0;
          phase_d   = ST_SEQ;
        end else if (stream_byte_i == CodePicture) begin
          phase_d = ST_PSKIP;
        end else begin
          push    = 1'b1;
          phase_d = ST_SEARCH;
        end
      end
      ST_SEQ: begin
        push = 1'b1;
        if (hdr_cnt_q != 2'd3) begin
          push_req_o.op = OP_SEQ_BYTE;
          hdr_cnt_d     = hdr_cnt_q + 2'd1;
        end else begin
          push_req_o.op = OP_SEQ_LAST;
          hdr_cnt_d     = 2'd0;
          phase_d       = ST_SEARCH;
        end
      end
      ST_PSKIP: phase_d = ST_PREAD;
      ST_PREAD: begin
        push          = 1'b1;
        push_req_o.op = OP_PIC_TYPE;
        phase_d       = ST_SEARCH;
      end
      default: begin
        phase_d = ST_SEARCH;
        if (stream_byte_i == 8'h00) begin
          if (zero_run_q != 2'd2) zero_run_d = zero_run_q + 2'd1;
        end else if (stream_byte_i == CodeOne && zero_run_q == 2'd2) begin
          zero_run_d = 2'd0;
          phase_d    = ST_CODE;
        end else begin
          zero_run_d = 2'd0;
        end
      end
    endcase
  end

  assign push_valid_o = accept && push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ST_SEARCH;
      zero_run_q <= 2'd0;
      hdr_cnt_q  <= 2'd0;
    end else if (accept) begin
      phase_q    <= phase_d;
      zero_run_q <= zero_run_d;
      hdr_cnt_q  <= hdr_cnt_d;
    end
  end

endmodule

/* src/mscs_queue.sv */
module mscs_queue import mscs_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  mscs_req_t push_req_i,
  output logic      pop_valid_o,
  input  logic      pop_i,
  output mscs_req_t pop_req_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  mscs_req_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_req_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

/* src/mscs_back.sv */
module mscs_back import mscs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  mscs_req_t   req_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  event_kind_o,
  output logic [7:0]  code_value_o,
  output logic [11:0] frame_width_o,
  output logic [11:0] frame_height_o,
  output logic [3:0]  rate_code_o,
  output logic [15:0] rate_milli_fps_o,
  output logic [1:0]  picture_class_o
);

  logic        out_valid_q;
  logic [23:0] hdr_q;
  logic [3:0]  kind_q;
  logic [7:0]  code_q;
  logic [11:0] width_q, height_q;
  logic [3:0]  rc_q;
  logic [15:0] rate_q;
  logic [1:0]  pic_q;
  logic        slot_free;
  logic        emits;
  logic        load;

  assign slot_free = !out_valid_q || out_ready_i;
  assign emits     = (req_i.op != OP_SEQ_BYTE);
  assign pop_o     = req_valid_i && (slot_free || !emits);
  assign load      = pop_o && emits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && req_i.op == OP_SEQ_BYTE) hdr_q <= {hdr_q[15:0], req_i.data};
    if (load) begin
      unique case (req_i.op)
        OP_SEQ_LAST: begin
          kind_q   <= KindSeqHdr;
          code_q   <= CodeSeqHdr;
          width_q  <= {hdr_q[23:16], hdr_q[15:12]};
          height_q <= {hdr_q[11:8], hdr_q[7:0]};
          rc_q     <= req_i.data[3:0];
          rate_q   <= rate_lookup(req_i.data[3:0]);
          pic_q    <= '0;
        end
        OP_PIC_TYPE: begin
          kind_q   <= KindPicture;
          code_q   <= CodePicture;
          width_q  <= '0;
          height_q <= '0;
          rc_q     <= '0;
          rate_q   <= '0;
          pic_q    <= picture_lookup(req_i.data);
        end
        default: begin
          kind_q   <= classify_code(req_i.data);
          code_q   <= req_i.data;
          width_q  <= '0;
          height_q <= '0;
          rc_q     <= '0;
          rate_q   <= '0;
          pic_q    <= '0;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = kind_q;
  assign code_value_o     = code_q;
  assign frame_width_o    = width_q;
  assign frame_height_o   = height_q;
  assign rate_code_o      = rc_q;
  assign rate_milli_fps_o = rate_q;
  assign picture_class_o  = pic_q;

endmodule

/* bench/start_code_event_checker.sv */
module start_code_event_checker import mscs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  stream_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  event_kind_i,
  input  logic [7:0]  code_value_i,
  input  logic [11:0] frame_width_i,
  input  logic [11:0] frame_height_i,
  input  logic [3:0]  rate_code_i,
  input  logic [15:0] rate_milli_fps_i,
  input  logic [1:0]  picture_class_i,
  output int unsigned events_outstanding_o,
  output int unsigned mismatches_o
);

  typedef enum logic [2:0] {
    HUNT,
    CODE_BYTE,
    SEQ_FIELDS,
    PIC_SKIP,
    PIC_TYPE
  } scan_phase_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  code;
    logic [11:0] width;
    logic [11:0] height;
    logic [3:0]  rate_code;
    logic [15:0] rate;
    logic [1:0]  pic;
  } start_code_event_t;

  scan_phase_e       phase;
  logic [1:0]        zero_run;
  logic [23:0]       seq_bytes;
  logic [1:0]        seq_count;
  start_code_event_t events_q[$];
  int unsigned       mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  function automatic logic [3:0] kind_of(input logic [7:0] c);
    if (c == CodePicture) return KindPicture;
    if (c <= SliceLast) return KindSlice;
    if (c == CodePack) return KindPack;
    if (c == CodeSystem) return KindSystem;
    if (c == CodeSeqHdr) return KindSeqHdr;
    if (c == CodeGop) return KindGop;
    if (c >= AudioFirst && c <= AudioLast) return KindAudio;
    if (c >= VideoFirst) return KindVideo;
    return KindOther;
  endfunction

  function automatic logic [15:0] milli_fps(input logic [3:0] rc);
    case (rc)
      4'd1:    return 16'd23976;
      4'd2:    return 16'd24000;
      4'd3:    return 16'd25000;
      4'd4:    return 16'd29970;
      4'd5:    return 16'd30000;
      4'd6:    return 16'd50000;
      4'd7:    return 16'd59940;
      default: return 16'd60000;
    endcase
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    start_code_event_t ev;
    ev = '0;
    case (phase)
      CODE_BYTE: begin
        zero_run = 2'd0;
        if (b == CodeSeqHdr) begin
          seq_bytes = '0;
          seq_count = 2'd0;
          phase = SEQ_FIELDS;
        end else if (b == CodePicture) begin
          phase = PIC_SKIP;
        end else begin
          phase = HUNT;
          ev.kind = kind_of(b);
          ev.code = b;
          events_q.push_back(ev);
        end
      end
      SEQ_FIELDS: begin
        if (seq_count < 2'd3) begin
          seq_bytes = {seq_bytes[15:0], b};
          seq_count = seq_count + 2'd1;
        end else begin
          ev.kind      = KindSeqHdr;
          ev.code      = CodeSeqHdr;
          ev.width     = {seq_bytes[23:16], seq_bytes[15:12]};
          ev.height    = seq_bytes[11:0];
          ev.rate_code = b[3:0];
          ev.rate      = milli_fps(b[3:0]);
          events_q.push_back(ev);
          seq_count = 2'd0;
          phase = HUNT;
        end
      end
      PIC_SKIP: phase = PIC_TYPE;
      PIC_TYPE: begin
        ev.kind = KindPicture;
        ev.code = CodePicture;
        if (b[5:3] == 3'd1) ev.pic = PicI;
        else if (b[5:3] == 3'd2) ev.pic = PicP;
        else ev.pic = PicOther;
        events_q.push_back(ev);
        phase = HUNT;
      end
      default: begin
        phase = HUNT;
        if (b == 8'h00) begin
          if (zero_run < 2'd2) zero_run = zero_run + 2'd1;
        end else if (b == CodeOne && zero_run >= 2'd2) begin
          zero_run = 2'd0;
          phase = CODE_BYTE;
        end else begin
          zero_run = 2'd0;
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_event();
    start_code_event_t want;
    if (events_q.size() == 0) begin
      $error("result with no start code pending: code_value %0h", code_value_i);
      mismatch_count++;
    end else begin
      want = events_q.pop_front();
      compare_field("event_kind", want.kind, event_kind_i);
      compare_field("code_value", want.code, code_value_i);
      compare_field("frame_width", want.width, frame_width_i);
      compare_field("frame_height", want.height, frame_height_i);
      compare_field("rate_code", want.rate_code, rate_code_i);
      compare_field("rate_milli_fps", want.rate, rate_milli_fps_i);
      compare_field("picture_class", want.pic, picture_class_i);
    end
  endtask

  // results pass through the queue and the output register after their last
  // byte, so the output side is handled before the byte accepted at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase = HUNT;
      zero_run = 2'd0;
      seq_bytes = '0;
      seq_count = 2'd0;
      events_q.delete();
      events_outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_event();
      if (in_valid_i && in_ready_i) predict_byte(stream_byte_i);
      events_outstanding_o <= events_q.size();
    end
  end

endmodule

/* bench/mpeg_start_code_scanner_core_test.sv */
module mpeg_start_code_scanner_core_test;
  import mscs_pkg::*;

  localparam int unsigned RandomBytes = 1000;
  localparam int unsigned CycleLimit  = 200000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  stream_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  event_kind_o;
  logic [7:0]  code_value_o;
  logic [11:0] frame_width_o;
  logic [11:0] frame_height_o;
  logic [3:0]  rate_code_o;
  logic [15:0] rate_milli_fps_o;
  logic [1:0]  picture_class_o;

  int unsigned events_outstanding;
  int unsigned mismatches;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  logic [1:0]  stall_mode = 2'd0;
  logic        drained_once = 1'b0;

  mpeg_start_code_scanner_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .stream_byte_i    (stream_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_o     (event_kind_o),
    .code_value_o     (code_value_o),
    .frame_width_o    (frame_width_o),
    .frame_height_o   (frame_height_o),
    .rate_code_o      (rate_code_o),
    .rate_milli_fps_o (rate_milli_fps_o),
    .picture_class_o  (picture_class_o)
  );

  start_code_event_checker checker_i (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_i           (in_ready_o),
    .stream_byte_i        (stream_byte_i),
    .out_valid_i          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .event_kind_i         (event_kind_o),
    .code_value_i         (code_value_o),
    .frame_width_i        (frame_width_o),
    .frame_height_i       (frame_height_o),
    .rate_code_i          (rate_code_o),
    .rate_milli_fps_i     (rate_milli_fps_o),
    .picture_class_i      (picture_class_o),
    .events_outstanding_o (events_outstanding),
    .mismatches_o         (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: switches at random between stall patterns
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= 1'($urandom_range(0, 1));
      2'd2: out_ready_i <= ($urandom_range(0, 5) == 0);
      default: out_ready_i <= cycles[3];
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = $urandom_range(1, 60);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (events_outstanding != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_code();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = CodePack;
      1: c = CodeSystem;
      2, 3: c = CodeSeqHdr;
      4: c = CodeGop;
      5, 6: c = CodePicture;
      7: c = 8'($urandom_range(CodeOne, SliceLast));
      8: begin
        case ($urandom_range(0, 2))
          0: c = 8'($urandom_range(AudioFirst, AudioLast));
          1: c = 8'($urandom_range(VideoFirst, 8'hFF));
          default: begin
            do c = 8'($urandom_range(8'hB0, 8'hBF));
            while (c == CodePack || c == CodeSystem || c == CodeSeqHdr || c == CodeGop);
          end
        endcase
      end
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // header bytes lean toward 00 and 01 so that false prefixes show up inside
  function automatic logic [7:0] pick_body_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return CodeOne;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_start_code();
    logic [7:0] c;
    c = pick_code();
    repeat ($urandom_range(2, 4)) send_byte(8'h00);
    send_byte(CodeOne);
    send_byte(c);
    if (c == CodeSeqHdr) begin
      repeat (4) send_byte(pick_body_byte());
    end else if (c == CodePicture) begin
      send_byte(pick_body_byte());
      send_byte({2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                 3'($urandom_range(0, 7))});
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 3))
        0, 1: send_byte(8'h00);
        2: send_byte(CodeOne);
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // long zero run, then pack
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(CodeOne);
    send_byte(CodePack);
    // sequence header at full width, rate code 0; its trailing zeros don't
    // start a prefix, so the following 00 01 is plain data
    send_byte(8'h00); send_byte(8'h00); send_byte(CodeOne); send_byte(CodeSeqHdr);
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h00); send_byte(CodeOne);
    // picture, I type
    send_byte(8'h00); send_byte(8'h00); send_byte(CodeOne); send_byte(CodePicture);
    send_byte(8'h55); send_byte(8'h08);
    // slice with code byte one
    send_byte(8'h00); send_byte(8'h00); send_byte(CodeOne); send_byte(CodeOne);

    while (bytes_sent < RandomBytes + 25) begin
      if ($urandom_range(0, 3) != 0) send_start_code();
      else send_noise();
      if (!drained_once && bytes_sent > RandomBytes / 2) begin
        wait_drained();
        drained_once = 1'b1;
      end
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
src/mscs_pkg.sv
src/mscs_front.sv
src/mscs_queue.sv
src/mscs_back.sv
src/mpeg_start_code_scanner_core.sv
bench/start_code_event_checker.sv
bench/mpeg_start_code_scanner_core_test.sv
